### hdl/hafc_pkg.sv
// shared types, constants and helpers for the hot air heater and fan controller
`default_nettype none

package hafc_pkg;

   localparam int RAW_W      = 10;
   localparam int TEMP_W     = 10;
   localparam int FAN_W      = 7;
   localparam int PWM_W      = 8;
   localparam int GAIN_W     = 8;
   localparam int MARGIN_W   = 8;
   localparam int DELAY_W    = 13;
   localparam int KNOB_W     = 10;
   localparam int STEP_W     = 4;
   localparam int ACC_W      = 18;
   localparam int MPLIER_W   = 8;
   localparam int QUOT_W     = 10;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 10;

   localparam int MUL_STEPS  = 8;
   localparam int DIV_STEPS  = QUOT_W;

   localparam logic [CNT_W-1:0] CNT_MUL = CNT_W'(MUL_STEPS - 1);
   localparam logic [CNT_W-1:0] CNT_DIV = CNT_W'(DIV_STEPS - 1);

   localparam int RAW_LO_I     = 55;
   localparam int RAW_HI_I     = 140;
   localparam int FULL_SPEED_I = 100;
   localparam int KNOB_STEP_I  = 5;

   localparam logic [RAW_W-1:0]  RAW_LO          = RAW_W'(RAW_LO_I);
   localparam logic [RAW_W-1:0]  RAW_HI          = RAW_W'(RAW_HI_I);
   localparam logic [FAN_W-1:0]  FULL_SPEED      = FAN_W'(FULL_SPEED_I);
   localparam logic [KNOB_W-1:0] FULL_SPEED_KNOB = KNOB_W'(FULL_SPEED_I / KNOB_STEP_I);
   localparam logic [KNOB_W-1:0] KNOB_MAX        = KNOB_W'(1023 / KNOB_STEP_I);
   localparam logic [ACC_W-1:0]  DELAY_MIN       = ACC_W'(3000);
   localparam logic [ACC_W-1:0]  DELAY_MAX       = ACC_W'(8500);
   localparam logic [DELAY_W-1:0] FIRE_MAX       = DELAY_W'(8500 - 3000);
   localparam logic [ACC_W-1:0]  DIV_TOP_TEMP    =
      ACC_W'((RAW_HI_I - RAW_LO_I) * (2 ** (DIV_STEPS - 1)));
   localparam logic [ACC_W-1:0]  DIV_TOP_FAN     =
      ACC_W'(FULL_SPEED_I * (2 ** (DIV_STEPS - 1)));
   localparam logic [ACC_W-1:0]  RECIP_5         = ACC_W'(205);

   localparam logic [GAIN_W-1:0]   GAIN_RST          = GAIN_W'(50);
   localparam logic [TEMP_W-1:0]   MIN_TEMP_RST      = TEMP_W'(200);
   localparam logic [TEMP_W-1:0]   MAX_TEMP_RST      = TEMP_W'(450);
   localparam logic [FAN_W-1:0]    MIN_FAN_RST       = FAN_W'(10);
   localparam logic [PWM_W-1:0]    MIN_PWM_RST       = PWM_W'(120);
   localparam logic [PWM_W-1:0]    MAX_PWM_RST       = PWM_W'(255);
   localparam logic [MARGIN_W-1:0] MARGIN_RST        = MARGIN_W'(5);
   localparam logic [RAW_W-1:0]    FAN_THRESHOLD_RST = RAW_W'(20);
   localparam logic [TEMP_W-1:0]   TARGET_RST        = TEMP_W'(350);
   localparam logic [FAN_W-1:0]    FAN_PERCENT_RST   = FAN_W'(50);

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN          = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TEMP      = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TEMP      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FAN_SPEED = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PWM       = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PWM       = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_MARGIN  = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_FAN_THRESHOLD = CSR_IDX_W'(7);

   typedef struct packed {
      logic [RAW_W-1:0]         raw_sample;
      logic                     heater_switch;
      logic signed [STEP_W-1:0] encoder_step;
      logic                     button_click;
   } req_type;

   typedef struct packed {
      logic [PWM_W-1:0]   fan_duty;
      logic               heater_enable;
      logic [DELAY_W-1:0] firing_delay;
      logic [TEMP_W-1:0]  setpoint;
      logic [FAN_W-1:0]   fan_speed;
      logic [TEMP_W-1:0]  measured_temp;
      logic               editing_setpoint;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic mul_en;
      logic div_en;
   } lane_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KNOB,
      ST_RELOAD,
      ST_MUL,
      ST_DIV,
      ST_MEAS,
      ST_PROD,
      ST_DONE
   } state_type;

   // floor(v / 5) for any 10 bit value, by reciprocal multiply
   function automatic logic [KNOB_W-1:0] div5(input logic [TEMP_W-1:0] v);
      logic [ACC_W-1:0] p;
      p = ACC_W'(v) * RECIP_5;
      return KNOB_W'(p[ACC_W-1:TEMP_W]);
   endfunction

endpackage

`default_nettype wire

### hdl/hafc_lane.sv
// bit-serial shift-add multiplier followed by shift-subtract divider by a constant
`default_nettype none

module hafc_lane (
   input  wire                                clock,
   input  wire hafc_pkg::lane_ctrl_type       ctrl,
   input  wire [hafc_pkg::ACC_W-1:0]          mcand_load,
   input  wire [hafc_pkg::MPLIER_W-1:0]       mplier_load,
   input  wire [hafc_pkg::ACC_W-1:0]          div_top,
   output logic [hafc_pkg::ACC_W-1:0]         acc,
   output logic [hafc_pkg::QUOT_W-1:0]        quot
);

   logic [hafc_pkg::ACC_W-1:0]    mcand_ff, mcand_in;
   logic [hafc_pkg::MPLIER_W-1:0] mplier_ff, mplier_in;
   logic [hafc_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [hafc_pkg::QUOT_W-1:0]   quot_ff, quot_in;
   logic [hafc_pkg::ACC_W-1:0]    diff;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      quot_in   = quot_ff;
      diff      = acc_ff - div_top;
      if (ctrl.load) begin
         mcand_in  = mcand_load;
         mplier_in = mplier_load;
         acc_in    = '0;
         quot_in   = '0;
      end else if (ctrl.mul_en) begin
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_in  = {mcand_ff[hafc_pkg::ACC_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[hafc_pkg::MPLIER_W-1:1]};
      end else if (ctrl.div_en) begin
         if (acc_ff >= div_top) begin
            acc_in  = {diff[hafc_pkg::ACC_W-2:0], 1'b0};
            quot_in = {quot_ff[hafc_pkg::QUOT_W-2:0], 1'b1};
         end else begin
            acc_in  = {acc_ff[hafc_pkg::ACC_W-2:0], 1'b0};
            quot_in = {quot_ff[hafc_pkg::QUOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      quot_ff   <= quot_in;
   end

   assign acc  = acc_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

### hdl/hot_air_heater_fan_controller.sv
// top level of the hot air heater and fan controller, one control pass per item
// Usage:
//   req_* carries one control pass (raw sample, switch, encoder step, click);
//   rsp_* returns one result item per pass (fan duty, heater enable, firing
//   delay, setpoint, fan speed, measured temperature, edit mode).
//   csr_* writes the eight control registers by index; it is always ready and
//   should only be used while no pass is in flight.
// Sequence:
//   an accepted item runs knob update, click reload, 8 multiply steps and
//   10 divide steps on two bit-serial lanes, a combine step, then 8 steps
//   of the gain multiply on the temperature lane, then waits in the done state.
//   req_ready is high only when the sequencer is idle, so a new item is taken
//   only once the previous result has moved into the output register.
// Reset (synchronous, active high): control and sequencer registers return
//   to defaults: setpoint 350, fan speed 50, fan speed edit mode, no result pending.
// Stall: the result sits in an output register; a new item is accepted
//   while it waits, and the next result holds in the done state until
//   the output register is free.
`default_nettype none

module hot_air_heater_fan_controller (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire hafc_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output hafc_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [hafc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [hafc_pkg::CSR_DATA_W-1:0]       csr_data
);

   // control registers
   logic [hafc_pkg::GAIN_W-1:0]   gain_ff;
   logic [hafc_pkg::TEMP_W-1:0]   min_temp_ff;
   logic [hafc_pkg::TEMP_W-1:0]   max_temp_ff;
   logic [hafc_pkg::FAN_W-1:0]    min_fan_ff;
   logic [hafc_pkg::PWM_W-1:0]    min_pwm_ff;
   logic [hafc_pkg::PWM_W-1:0]    max_pwm_ff;
   logic [hafc_pkg::MARGIN_W-1:0] margin_ff;
   logic [hafc_pkg::RAW_W-1:0]    fan_threshold_ff;

   // sequencer and state
   hafc_pkg::state_type           state_ff, state_in;
   logic [hafc_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   hafc_pkg::req_type             item_ff;
   logic signed [hafc_pkg::KNOB_W-1:0] knob_ff;
   logic [hafc_pkg::TEMP_W-1:0]   target_ff;
   logic [hafc_pkg::FAN_W-1:0]    fan_ff;
   logic                          mode_ff;
   logic [hafc_pkg::TEMP_W-1:0]   measured_ff;
   logic [hafc_pkg::PWM_W-1:0]    duty_ff;
   logic                          heat_ff;
   logic                          rsp_valid_ff;
   hafc_pkg::rsp_type             rsp_ff;

   logic                          req_accept;
   logic                          rsp_load;
   hafc_pkg::lane_ctrl_type       ctrl_a, ctrl_b;

   // lane operands and results
   logic [hafc_pkg::ACC_W-1:0]    mcand_a, mcand_b;
   logic [hafc_pkg::MPLIER_W-1:0] mplier_a, mplier_b;
   logic [hafc_pkg::ACC_W-1:0]    acc_a, acc_b;
   logic [hafc_pkg::QUOT_W-1:0]   quot_a, quot_b;

   // datapath
   logic [hafc_pkg::RAW_W-1:0]    raw_clamped;
   logic [hafc_pkg::RAW_W-1:0]    raw_offset;
   logic                          temp_neg;
   logic [hafc_pkg::TEMP_W-1:0]   temp_span;
   logic                          pwm_neg;
   logic [hafc_pkg::PWM_W-1:0]    pwm_span;
   logic signed [hafc_pkg::KNOB_W+1:0] knob_x, knob5;
   logic signed [hafc_pkg::KNOB_W+1:0] hi12, lo12, full12, lof12;
   logic signed [hafc_pkg::KNOB_W+1:0] t_val, f_val;
   logic signed [hafc_pkg::KNOB_W-1:0] t_knob, f_knob;
   logic [hafc_pkg::TEMP_W-1:0]   reload_src;
   logic signed [hafc_pkg::KNOB_W+1:0] q_a, q_b, meas_s, duty_s, err_s;
   logic [hafc_pkg::PWM_W-1:0]    duty_sat;
   logic                          fan_run;
   logic                          heat;
   logic [hafc_pkg::ACC_W-1:0]    p_clamped;
   logic [hafc_pkg::ACC_W-1:0]    fire_full;
   logic [hafc_pkg::DELAY_W-1:0]  fire;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff          <= hafc_pkg::GAIN_RST;
         min_temp_ff      <= hafc_pkg::MIN_TEMP_RST;
         max_temp_ff      <= hafc_pkg::MAX_TEMP_RST;
         min_fan_ff       <= hafc_pkg::MIN_FAN_RST;
         min_pwm_ff       <= hafc_pkg::MIN_PWM_RST;
         max_pwm_ff       <= hafc_pkg::MAX_PWM_RST;
         margin_ff        <= hafc_pkg::MARGIN_RST;
         fan_threshold_ff <= hafc_pkg::FAN_THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hafc_pkg::CSR_GAIN:          gain_ff <= csr_data[hafc_pkg::GAIN_W-1:0];
            hafc_pkg::CSR_MIN_TEMP:      min_temp_ff <= csr_data[hafc_pkg::TEMP_W-1:0];
            hafc_pkg::CSR_MAX_TEMP:      max_temp_ff <= csr_data[hafc_pkg::TEMP_W-1:0];
            hafc_pkg::CSR_MIN_FAN_SPEED: min_fan_ff <= csr_data[hafc_pkg::FAN_W-1:0];
            hafc_pkg::CSR_MIN_PWM:       min_pwm_ff <= csr_data[hafc_pkg::PWM_W-1:0];
            hafc_pkg::CSR_MAX_PWM:       max_pwm_ff <= csr_data[hafc_pkg::PWM_W-1:0];
            hafc_pkg::CSR_ERROR_MARGIN:  margin_ff <= csr_data[hafc_pkg::MARGIN_W-1:0];
            hafc_pkg::CSR_FAN_THRESHOLD: fan_threshold_ff <= csr_data[hafc_pkg::RAW_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hafc_pkg::ST_IDLE:   if (req_accept) state_in = hafc_pkg::ST_KNOB;
         hafc_pkg::ST_KNOB:   state_in = hafc_pkg::ST_RELOAD;
         hafc_pkg::ST_RELOAD: state_in = hafc_pkg::ST_MUL;
         hafc_pkg::ST_MUL:    if (cnt_ff == '0) state_in = hafc_pkg::ST_DIV;
         hafc_pkg::ST_DIV:    if (cnt_ff == '0) state_in = hafc_pkg::ST_MEAS;
         hafc_pkg::ST_MEAS:   state_in = hafc_pkg::ST_PROD;
         hafc_pkg::ST_PROD:   if (cnt_ff == '0) state_in = hafc_pkg::ST_DONE;
         hafc_pkg::ST_DONE:   if (rsp_load) state_in = hafc_pkg::ST_IDLE;
         default:             state_in = hafc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      ctrl_a    = '0;
      ctrl_b    = '0;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         hafc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            ctrl_a.load = req_accept;
            ctrl_b.load = req_accept;
         end
         hafc_pkg::ST_KNOB: ;
         hafc_pkg::ST_RELOAD: begin
            cnt_in = hafc_pkg::CNT_MUL;
         end
         hafc_pkg::ST_MUL: begin
            ctrl_a.mul_en = 1'b1;
            ctrl_b.mul_en = 1'b1;
            cnt_in = (cnt_ff == '0) ? hafc_pkg::CNT_DIV : cnt_ff - 1'b1;
         end
         hafc_pkg::ST_DIV: begin
            ctrl_a.div_en = 1'b1;
            ctrl_b.div_en = 1'b1;
            cnt_in = cnt_ff - 1'b1;
         end
         hafc_pkg::ST_MEAS: begin
            ctrl_a.load = 1'b1;
            cnt_in      = hafc_pkg::CNT_MUL;
         end
         hafc_pkg::ST_PROD: begin
            ctrl_a.mul_en = 1'b1;
            cnt_in = cnt_ff - 1'b1;
         end
         hafc_pkg::ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
   end

   // operand set-up
   always_comb begin
      raw_clamped = req_data.raw_sample;
      if (req_data.raw_sample < hafc_pkg::RAW_LO) raw_clamped = hafc_pkg::RAW_LO;
      if (req_data.raw_sample > hafc_pkg::RAW_HI) raw_clamped = hafc_pkg::RAW_HI;
      raw_offset = raw_clamped - hafc_pkg::RAW_LO;
      temp_neg   = max_temp_ff < min_temp_ff;
      temp_span  = temp_neg ? min_temp_ff - max_temp_ff : max_temp_ff - min_temp_ff;
      pwm_neg    = max_pwm_ff < min_pwm_ff;
      pwm_span   = pwm_neg ? min_pwm_ff - max_pwm_ff : max_pwm_ff - min_pwm_ff;
   end

   always_comb begin
      mcand_b  = hafc_pkg::ACC_W'(pwm_span);
      mplier_b = hafc_pkg::MPLIER_W'(fan_ff);
      if (state_ff == hafc_pkg::ST_MEAS) begin
         mcand_a  = hafc_pkg::ACC_W'(err_s[hafc_pkg::TEMP_W-1:0]);
         mplier_a = hafc_pkg::MPLIER_W'(gain_ff);
      end else begin
         mcand_a  = hafc_pkg::ACC_W'(temp_span);
         mplier_a = hafc_pkg::MPLIER_W'(raw_offset);
      end
   end

   // knob to setpoint or fan speed, upper bound first then lower bound
   always_comb begin
      knob_x = {{2{knob_ff[hafc_pkg::KNOB_W-1]}}, knob_ff};
      knob5  = (knob_x <<< 2) + knob_x;
      hi12   = $signed({2'b00, max_temp_ff});
      lo12   = $signed({2'b00, min_temp_ff});
      full12 = $signed({5'b00000, hafc_pkg::FULL_SPEED});
      lof12  = $signed({5'b00000, min_fan_ff});
      t_val  = knob5;
      t_knob = knob_ff;
      if (t_val > hi12) begin
         t_val  = hi12;
         t_knob = hafc_pkg::div5(max_temp_ff);
      end
      if (t_val < lo12) begin
         t_val  = lo12;
         t_knob = hafc_pkg::div5(min_temp_ff);
      end
      f_val  = knob5;
      f_knob = knob_ff;
      if (f_val > full12) begin
         f_val  = full12;
         f_knob = hafc_pkg::FULL_SPEED_KNOB;
      end
      if (f_val < lof12) begin
         f_val  = lof12;
         f_knob = hafc_pkg::div5(hafc_pkg::TEMP_W'(min_fan_ff));
      end
      reload_src = !mode_ff ? target_ff : hafc_pkg::TEMP_W'(fan_ff);
   end

   // combine quotients into temperature, duty and error
   always_comb begin
      q_a      = $signed({2'b00, quot_a});
      q_b      = $signed({2'b00, quot_b});
      meas_s   = lo12 + (temp_neg ? -q_a : q_a);
      duty_s   = $signed({4'b0000, min_pwm_ff}) + (pwm_neg ? -q_b : q_b);
      duty_sat = duty_s[hafc_pkg::PWM_W-1:0];
      if (duty_s < 0) duty_sat = '0;
      if (duty_s > $signed({4'b0000, {hafc_pkg::PWM_W{1'b1}}})) duty_sat = '1;
      fan_run  = item_ff.heater_switch || (item_ff.raw_sample > fan_threshold_ff);
      err_s    = $signed({2'b00, target_ff}) - meas_s;
      heat     = item_ff.heater_switch && (err_s > $signed({4'b0000, margin_ff}));
   end

   always_comb begin
      p_clamped = acc_a;
      if (acc_a < hafc_pkg::DELAY_MIN) p_clamped = hafc_pkg::DELAY_MIN;
      if (acc_a > hafc_pkg::DELAY_MAX) p_clamped = hafc_pkg::DELAY_MAX;
      fire_full = hafc_pkg::DELAY_MAX - p_clamped;
      fire      = heat_ff ? fire_full[hafc_pkg::DELAY_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hafc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         knob_ff      <= '0;
         target_ff    <= hafc_pkg::TARGET_RST;
         fan_ff       <= hafc_pkg::FAN_PERCENT_RST;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (req_accept) begin
            knob_ff <= knob_ff + {{(hafc_pkg::KNOB_W - hafc_pkg::STEP_W)
                                   {req_data.encoder_step[hafc_pkg::STEP_W-1]}},
                                  req_data.encoder_step};
         end
         if (state_ff == hafc_pkg::ST_KNOB) begin
            if (mode_ff) begin
               target_ff <= t_val[hafc_pkg::TEMP_W-1:0];
               knob_ff   <= t_knob;
            end else begin
               fan_ff  <= f_val[hafc_pkg::FAN_W-1:0];
               knob_ff <= f_knob;
            end
         end
         if (state_ff == hafc_pkg::ST_RELOAD && item_ff.button_click) begin
            mode_ff <= !mode_ff;
            knob_ff <= hafc_pkg::div5(reload_src);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      if (state_ff == hafc_pkg::ST_MEAS) begin
         measured_ff <= meas_s[hafc_pkg::TEMP_W-1:0];
         duty_ff     <= fan_run ? duty_sat : '0;
         heat_ff     <= heat;
      end
      if (rsp_load) begin
         rsp_ff.fan_duty         <= duty_ff;
         rsp_ff.heater_enable    <= heat_ff;
         rsp_ff.firing_delay     <= fire;
         rsp_ff.setpoint         <= target_ff;
         rsp_ff.fan_speed        <= fan_ff;
         rsp_ff.measured_temp    <= measured_ff;
         rsp_ff.editing_setpoint <= mode_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   hafc_lane u_lane_temp (
      .clock       (clock),
      .ctrl        (ctrl_a),
      .mcand_load  (mcand_a),
      .mplier_load (mplier_a),
      .div_top     (hafc_pkg::DIV_TOP_TEMP),
      .acc         (acc_a),
      .quot        (quot_a)
   );

   hafc_lane u_lane_fan (
      .clock       (clock),
      .ctrl        (ctrl_b),
      .mcand_load  (mcand_b),
      .mplier_load (mplier_b),
      .div_top     (hafc_pkg::DIV_TOP_FAN),
      .acc         (acc_b),
      .quot        (quot_b)
   );

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == hafc_pkg::ST_KNOB)
      else $error("accepted item did not start the sequencer");

   a_knob_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == hafc_pkg::ST_MUL |-> knob_ff >= 0 &&
         knob_ff <= $signed(hafc_pkg::KNOB_MAX))
      else $error("knob position out of range after update");

   a_div_temp_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == hafc_pkg::ST_DIV |-> acc_a < (hafc_pkg::DIV_TOP_TEMP << 1))
      else $error("temperature lane remainder out of range");

   a_div_fan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == hafc_pkg::ST_DIV |-> acc_b < (hafc_pkg::DIV_TOP_FAN << 1))
      else $error("fan lane remainder out of range");

   a_fire_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.heater_enable && rsp_ff.firing_delay <= hafc_pkg::FIRE_MAX) ||
         (!rsp_ff.heater_enable && rsp_ff.firing_delay == '0))
      else $error("firing delay inconsistent with heater enable");
`endif

endmodule

`default_nettype wire
